// ===== src/isc_pkg.sv =====
`timescale 1ns / 1ps
package isc_pkg;

  localparam int MAX_EVENTS = 256;
  localparam int CNT_W      = $clog2(MAX_EVENTS + 1);
  localparam int TIME_W     = 16;
  localparam int KEY_W      = 2 * TIME_W;
  localparam int SEL_W      = 9;
  localparam int SEL_MAX    = (1 << SEL_W) - 1;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic              is_empty_set;
    logic              last_event;
  } isc_in_t;

  typedef struct packed {
    logic [SEL_W-1:0] selected_count;
    logic             overflow;
  } isc_out_t;

  // per-cycle command to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift;
  } isc_cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic step;
  } isc_scan_ctrl_t;

endpackage

// ===== src/isc_cell.sv =====
`timescale 1ns / 1ps
module isc_cell (
  input  logic                  clk,
  input  isc_pkg::isc_cell_ctrl_t ctrl,
  input  logic                  occupied,
  input  logic [isc_pkg::KEY_W-1:0] new_key,
  input  logic [isc_pkg::KEY_W-1:0] prev_key,
  input  logic                  prev_gt,
  input  logic [isc_pkg::KEY_W-1:0] next_key,
  output logic [isc_pkg::KEY_W-1:0] key,
  output logic                  gt
);
  import isc_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;

  // an empty cell counts as greater than any key, so the new key lands at
  // the first cell that is empty or holds a larger key
  assign gt  = !occupied || (key_r > new_key);
  assign key = key_r;

  always_comb begin
    key_nxt = key_r;
    if (ctrl.insert && gt) begin
      key_nxt = prev_gt ? prev_key : new_key;
    end else if (ctrl.shift) begin
      key_nxt = next_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ===== src/isc_scan.sv =====
`timescale 1ns / 1ps
module isc_scan (
  input  logic                      clk,
  input  isc_pkg::isc_scan_ctrl_t   ctrl,
  input  logic [isc_pkg::KEY_W-1:0] head_key,
  output logic [isc_pkg::CNT_W-1:0] picked
);
  import isc_pkg::*;

  logic [TIME_W-1:0] last_end_r;
  logic [TIME_W-1:0] last_end_nxt;
  logic [CNT_W-1:0]  picked_r;
  logic [CNT_W-1:0]  picked_nxt;
  logic [TIME_W-1:0] head_start;
  logic [TIME_W-1:0] head_end;
  logic              take;

  assign head_start = head_key[TIME_W-1:0];
  assign head_end   = head_key[KEY_W-1:TIME_W];
  // first event is always picked
  assign take       = (picked_r == '0) || (last_end_r <= head_start);
  assign picked     = picked_r;

  always_comb begin
    picked_nxt   = picked_r;
    last_end_nxt = last_end_r;
    if (ctrl.clear) begin
      picked_nxt = '0;
    end else if (ctrl.step && take) begin
      picked_nxt   = picked_r + 1'b1;
      last_end_nxt = head_end;
    end
  end

  always_ff @(posedge clk) begin
    picked_r   <= picked_nxt;
    last_end_r <= last_end_nxt;
  end

endmodule

// ===== src/interval_schedule_counter_core.sv =====
`timescale 1ns / 1ps
// Greedy interval-scheduling counter.
// Input: one event per beat (start_time, end_time), taken when start is high
// and busy is low. is_empty_set marks a beat that carries no event;
// last_event closes the set.
// Events are insertion-sorted by (end_time, start_time) into a row of
// MAX_EVENTS cells, one event per cycle, so busy stays low while a set is
// being loaded. Events arriving with the row full are dropped and flagged.
// On the last beat busy rises and the row shifts toward cell 0, one event a
// cycle, past the greedy picker. busy falls in the cycle the result is
// shown.
// Output: out_valid is high for exactly one cycle with selected_count
// (saturated at 511) and overflow. The receiver cannot stall the block.
// After a result the row and the overflow flag are empty for the next set.
// Reset (rst_n low, synchronous) empties the row and drops any scan.
module interval_schedule_counter_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  isc_pkg::isc_in_t  in_item,
  output logic             out_valid,
  output isc_pkg::isc_out_t out_result
);
  import isc_pkg::*;

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  localparam int WIDE_W = (CNT_W > SEL_W) ? CNT_W : SEL_W;

  state_t           state_r;
  state_t           state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             overflow_r;
  logic             overflow_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  isc_out_t         out_result_r;
  isc_out_t         out_result_nxt;

  logic             accept;
  logic             has_event;
  logic             room;
  logic [KEY_W-1:0] new_key;
  logic [KEY_W-1:0] key [MAX_EVENTS];
  logic             gt  [MAX_EVENTS];
  isc_cell_ctrl_t   cell_ctrl;
  isc_scan_ctrl_t   scan_ctrl;
  logic [CNT_W-1:0] picked;
  logic [WIDE_W-1:0] picked_wide;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign has_event = accept && !in_item.is_empty_set;
  assign room      = (count_r < CNT_W'(MAX_EVENTS));
  assign new_key   = {in_item.end_time, in_item.start_time};

  assign cell_ctrl.insert = has_event && room;
  assign cell_ctrl.shift  = (state_r == ST_SCAN) && (count_r != '0);
  assign scan_ctrl.clear  = (state_r == ST_IDLE);
  assign scan_ctrl.step   = cell_ctrl.shift;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_EVENTS; gi++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);
      logic [KEY_W-1:0] prev_key;
      logic             prev_gt;
      logic [KEY_W-1:0] next_key;
      if (gi == 0) begin : g_head
        assign prev_key = '0;
        assign prev_gt  = 1'b0;
      end else begin : g_body
        assign prev_key = key[gi-1];
        assign prev_gt  = gt[gi-1];
      end
      if (gi == MAX_EVENTS - 1) begin : g_tail
        assign next_key = '0;
      end else begin : g_mid
        assign next_key = key[gi+1];
      end
      isc_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .occupied (IDX < count_r),
        .new_key  (new_key),
        .prev_key (prev_key),
        .prev_gt  (prev_gt),
        .next_key (next_key),
        .key      (key[gi]),
        .gt       (gt[gi])
      );
    end
  endgenerate

  isc_scan u_scan (
    .clk      (clk),
    .ctrl     (scan_ctrl),
    .head_key (key[0]),
    .picked   (picked)
  );

  assign picked_wide = WIDE_W'(picked);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    overflow_nxt   = overflow_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    case (state_r)
      ST_IDLE: begin
        if (has_event) begin
          if (room) begin
            count_nxt = count_r + 1'b1;
          end else begin
            overflow_nxt = 1'b1;
          end
        end
        if (accept && in_item.last_event) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
        end else begin
          out_valid_nxt = 1'b1;
          out_result_nxt.selected_count = (picked_wide > WIDE_W'(SEL_MAX)) ?
                                          SEL_W'(SEL_MAX) : picked_wide[SEL_W-1:0];
          out_result_nxt.overflow = overflow_r;
          overflow_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_EVENTS))
    else $error("stored count above capacity");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cell_ctrl.insert |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not grow the row");

  a_result_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_IDLE && count_r == '0 && !overflow_r))
    else $error("result shown without an emptied row");

  a_no_shift_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(cell_ctrl.insert && cell_ctrl.shift))
    else $error("insert and shift in the same cycle");

endmodule

// ===== test/isc_schedule_checker.sv =====
`timescale 1ns / 1ps
module isc_schedule_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  isc_pkg::isc_in_t  in_item,
  input  logic              out_valid,
  input  isc_pkg::isc_out_t out_result,
  output int                fail_count,
  output int                pending,
  output int                sets_scored,
  output int                sets_overflowed
);
  import isc_pkg::*;

  // own copy of the sorted event row: {end_time, start_time}
  logic [KEY_W-1:0] sorted_keys [MAX_EVENTS];
  int               held;
  logic             dropped;
  isc_out_t         expected_tallies [$];
  int               fails;
  int               scored;
  int               overflowed;

  function automatic int count_compatible();
    int                picked;
    logic [TIME_W-1:0] last_end;
    if (held == 0) return 0;
    picked   = 1;
    last_end = sorted_keys[0][KEY_W-1:TIME_W];
    for (int i = 1; i < held; i++) begin
      if (last_end <= sorted_keys[i][TIME_W-1:0]) begin
        picked++;
        last_end = sorted_keys[i][KEY_W-1:TIME_W];
      end
    end
    return (picked > SEL_MAX) ? SEL_MAX : picked;
  endfunction

  function automatic void file_event(input logic [KEY_W-1:0] key);
    int pos;
    pos = held;
    while (pos > 0 && sorted_keys[pos-1] > key) begin
      sorted_keys[pos] = sorted_keys[pos-1];
      pos--;
    end
    sorted_keys[pos] = key;
    held++;
  endfunction

  always @(posedge clk) begin : watch
    isc_out_t tally;
    isc_out_t want;
    if (!rst_n) begin
      held       = 0;
      dropped    = 1'b0;
      fails      = 0;
      scored     = 0;
      overflowed = 0;
      expected_tallies.delete();
    end else begin
      if (start && !busy) begin
        if (!in_item.is_empty_set) begin
          if (held < MAX_EVENTS) file_event({in_item.end_time, in_item.start_time});
          else dropped = 1'b1;
        end
        if (in_item.last_event) begin
          tally.selected_count = SEL_W'(count_compatible());
          tally.overflow       = dropped;
          expected_tallies.insert(expected_tallies.size(), tally);
          held    = 0;
          dropped = 1'b0;
        end
      end
      if (out_valid) begin
        if (expected_tallies.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected result count %0d ovf %0b", $realtime,
                     out_result.selected_count, out_result.overflow);
          fails++;
        end else begin
          want = expected_tallies.pop_front();
          scored++;
          if (want.overflow) overflowed++;
          if (want.selected_count !== out_result.selected_count ||
              want.overflow !== out_result.overflow) begin
            if (fails < 10)
              $display("%0t: set %0d expected count %0d ovf %0b, got count %0d ovf %0b",
                       $realtime, scored, want.selected_count, want.overflow,
                       out_result.selected_count, out_result.overflow);
            fails++;
          end
        end
      end
    end
    fail_count      <= fails;
    pending         <= expected_tallies.size();
    sets_scored     <= scored;
    sets_overflowed <= overflowed;
  end

endmodule

// ===== test/tb_interval_schedule_counter_core.sv =====
`timescale 1ns / 1ps
module tb_interval_schedule_counter_core;
  import isc_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int TARGET_ITEMS = 1700;
  localparam int DRAIN_CYCLES = MAX_EVENTS + 40;

  logic     clk      = 1'b0;
  logic     rst_n    = 1'b0;
  logic     start    = 1'b0;
  isc_in_t  in_item  = '0;
  logic     busy;
  logic     out_valid;
  isc_out_t out_result;

  int fail_count;
  int pending;
  int sets_scored;
  int sets_overflowed;
  int idle_pct     = 0;
  int item_beats   = 0;
  int stall_cycles = 0;
  int idle_mix [4] = '{0, 72, 0, 16};

  always #10 clk = ~clk;

  interval_schedule_counter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  isc_schedule_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_result     (out_result),
    .fail_count     (fail_count),
    .pending        (pending),
    .sets_scored    (sets_scored),
    .sets_overflowed(sets_overflowed)
  );

  // watchdog: cycles without any beat moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("** interval_schedule_counter_core: FAILED **");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic isc_in_t beat_of(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e,
                                      input logic empty, input logic last);
    isc_in_t b;
    b.start_time   = s;
    b.end_time     = e;
    b.is_empty_set = empty;
    b.last_event   = last;
    return b;
  endfunction

  function automatic isc_in_t make_event(input int flavor, input logic last);
    logic [TIME_W-1:0] s;
    logic [TIME_W-1:0] e;
    case (flavor)
      0: begin
        s = TIME_W'($urandom_range(0, 65535));
        e = TIME_W'($urandom_range(0, 65535));
      end
      1: begin
        // tight range: lots of ties and touching intervals
        s = TIME_W'($urandom_range(0, 40));
        e = TIME_W'($urandom_range(0, 40));
      end
      2: begin
        s = TIME_W'($urandom_range(0, 65000));
        e = TIME_W'(s + $urandom_range(0, 300));
      end
      default: begin
        s = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        e = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
    endcase
    return beat_of(s, e, 1'b0, last);
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_beat(input isc_in_t beat);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= beat;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (!beat.is_empty_set || beat.last_event) item_beats++;
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_set(input int n, input int flavor);
    isc_in_t noise;
    logic    close_empty;
    noise       = beat_of(16'h0000, 16'h0000, 1'b1, 1'b0);
    close_empty = (n == 0) || ($urandom_range(0, 9) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        noise.start_time = TIME_W'($urandom_range(0, 65535));
        noise.end_time   = TIME_W'($urandom_range(0, 65535));
        send_beat(noise);
      end
      send_beat(make_event(flavor, !close_empty && i == n - 1));
    end
    if (close_empty) begin
      noise.last_event = 1'b1;
      send_beat(noise);
    end
  endtask

  initial begin
    int n;
    int r;
    int flavor;
    int set_idx;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed sets
    send_beat(beat_of(16'h0000, 16'h0000, 1'b1, 1'b1));   // empty set
    send_beat(beat_of(16'h0000, 16'h0000, 1'b0, 1'b1));   // single zero-length event
    send_beat(beat_of(16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    send_beat(beat_of(16'h0000, 16'hFFFF, 1'b0, 1'b0));
    send_beat(beat_of(16'h1234, 16'h4321, 1'b1, 1'b0));   // empty beat mid-set
    send_beat(beat_of(16'h0000, 16'h0000, 1'b1, 1'b1));   // set closed by an empty beat
    send_beat(beat_of(16'd100, 16'd10, 1'b0, 1'b0));      // start after end
    send_beat(beat_of(16'd5, 16'd20, 1'b0, 1'b1));
    send_beat(beat_of(16'd3, 16'd50, 1'b0, 1'b0));        // equal ends, order by start
    send_beat(beat_of(16'd1, 16'd50, 1'b0, 1'b0));
    send_beat(beat_of(16'd50, 16'd80, 1'b0, 1'b1));
    send_beat(beat_of(16'hAAAA, 16'h5555, 1'b0, 1'b0));
    send_beat(beat_of(16'h5555, 16'hAAAA, 1'b0, 1'b1));
    send_beat(beat_of(16'd7, 16'd7, 1'b0, 1'b0));         // start equal to last picked end
    send_beat(beat_of(16'd7, 16'd9, 1'b0, 1'b0));
    send_beat(beat_of(16'd9, 16'd9, 1'b0, 1'b1));
    wait_quiet();

    set_idx = 0;
    while (item_beats < TARGET_ITEMS) begin
      idle_pct = idle_mix[(set_idx / 6) % 4];
      if (set_idx % 30 == 29) wait_quiet();
      r = $urandom_range(0, 99);
      if (set_idx == 0) n = MAX_EVENTS + 3;          // past capacity
      else if (set_idx == 40) n = MAX_EVENTS;        // exactly full
      else if (r < 8) n = $urandom_range(0, 2);
      else if (r < 85) n = $urandom_range(3, 12);
      else n = $urandom_range(13, 48);
      r = $urandom_range(0, 9);
      flavor = (r < 6) ? 2 : (r < 8) ? 1 : (r < 9) ? 0 : 3;
      send_set(n, flavor);
      set_idx++;
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("Covered %0d event sets (%0d past capacity), %0d counted beats,", sets_scored,
             sets_overflowed, item_beats);
    $display("sender idle mixes of 0/72/0/16 percent, with drained pauses between sets.");
    if (fail_count == 0 && pending == 0) begin
      $display("** interval_schedule_counter_core: PASSED **");
    end else begin
      $display("** interval_schedule_counter_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/isc_pkg.sv
src/isc_cell.sv
src/isc_scan.sv
src/interval_schedule_counter_core.sv
test/isc_schedule_checker.sv
test/tb_interval_schedule_counter_core.sv
